[sv/sha1_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  // initial chaining values
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  // round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // round counter and block geometry
  localparam int unsigned RND_W      = 7;
  localparam logic [6:0]  LAST_ROUND = 7'd79;
  localparam logic [5:0]  FILL_FULL  = 6'd63;
  localparam logic [5:0]  PAD_FILL   = 6'd56;
  localparam logic [2:0]  LAST_IDX   = 3'd4;
  localparam logic [7:0]  PAD_MARK   = 8'h80;

  // working variables a..e
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1_vars_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LEN   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_ADD   = 6'b010000,
    ST_OUT   = 6'b100000
  } sha1_state_t;

endpackage

`default_nettype wire

[sv/sha1_hash_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming SHA-1 engine.
// Input channel in_*: one word per message byte. in_tdata[7:0] is the byte,
// in_tuser says the byte is present, in_tlast ends the message (with or
// without a byte, so an empty message is a bare tlast word).
// Output channel out_*: five digest words per message, most significant
// first; out_tdata[31:0] is the word, out_tdata[34:32] its index, out_tlast
// marks the fifth word.
// Flow: a byte that does not complete a 64-byte block is absorbed and the
// engine stays idle. A byte that completes a block is absorbed, then the block
// runs through the single shared round unit (one round per cycle) and is
// added into the chaining words. A last word then pads one byte per cycle
// (held while a full block is compressed), length bytes included, with an
// idle step before the length; one or two compressions precede the digest.
// in_tready is high only while the engine is idle; it is low while the
// digest waits, so a stalled receiver simply holds the engine in the output
// phase with the current word stable. After the fifth word is taken the
// engine re-initializes and accepts the next message.
// Reset (rst_n low, synchronous) restores the initial chaining words and
// clears the bit count and block fill; there is no clearing pass.

module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero[39:35]
  output logic        out_tlast   // last_word
);
  import sha1_pkg::*;

  sha1_state_t state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [23:0] acc_r;
  logic [31:0] w_r [16];
  sha1_vars_t  vars_r;
  sha1_vars_t  vars_step;
  logic [31:0] w_new;
  logic [31:0] chain_r [5];
  logic [63:0] bit_cnt_r;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic [2:0]  len_sel;
  logic        pad_first_r, pad_first_nxt;
  logic        ending_r, ending_nxt;
  logic        len_sent_r, len_sent_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        in_fire;
  logic        out_fire;
  logic        absorb;
  logic [7:0]  abs_byte;
  logic        block_full;
  logic        reinit;
  logic [31:0] out_word;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_fire  = out_tvalid && out_tready;

  // length bytes go out most significant first
  assign len_sel = 3'd7 - len_cnt_r;

  // shared round unit
  sha1_round u_round (
    .rnd_i   (rnd_r),
    .vars_i  (vars_r),
    .w0_i    (w_r[0]),
    .w2_i    (w_r[2]),
    .w8_i    (w_r[8]),
    .w13_i   (w_r[13]),
    .vars_o  (vars_step),
    .w_new_o (w_new)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    len_cnt_nxt   = len_cnt_r;
    pad_first_nxt = pad_first_r;
    ending_nxt    = ending_r;
    len_sent_nxt  = len_sent_r;
    out_idx_nxt   = out_idx_r;
    absorb        = 1'b0;
    abs_byte      = 8'h00;
    reinit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            absorb   = 1'b1;
            abs_byte = in_tdata;
          end
          if (in_tlast) begin
            ending_nxt    = 1'b1;
            pad_first_nxt = 1'b1;
          end
          if (in_tuser && (fill_r == FILL_FULL)) begin
            state_nxt = ST_ROUND;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_first_r || (fill_r != PAD_FILL)) begin
          absorb        = 1'b1;
          abs_byte      = pad_first_r ? PAD_MARK : 8'h00;
          pad_first_nxt = 1'b0;
          if (fill_r == FILL_FULL) begin
            state_nxt = ST_ROUND;
          end
        end else begin
          state_nxt   = ST_LEN;
          len_cnt_nxt = 3'd0;
        end
      end
      ST_LEN: begin
        absorb      = 1'b1;
        abs_byte    = bit_cnt_r[{len_sel, 3'b000} +: 8];
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (fill_r == FILL_FULL) begin
          state_nxt    = ST_ROUND;
          len_sent_nxt = 1'b1;
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (len_sent_r) begin
          state_nxt   = ST_OUT;
          out_idx_nxt = 3'd0;
        end else if (ending_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (out_idx_r == LAST_IDX) begin
            state_nxt    = ST_IDLE;
            reinit       = 1'b1;
            ending_nxt   = 1'b0;
            len_sent_nxt = 1'b0;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (absorb && (fill_r == FILL_FULL)) begin
      rnd_nxt = 7'd0;
    end
  end

  assign block_full = absorb && (fill_r == FILL_FULL);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= 7'd0;
      len_cnt_r   <= 3'd0;
      pad_first_r <= 1'b0;
      ending_r    <= 1'b0;
      len_sent_r  <= 1'b0;
      out_idx_r   <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      len_cnt_r   <= len_cnt_nxt;
      pad_first_r <= pad_first_nxt;
      ending_r    <= ending_nxt;
      len_sent_r  <= len_sent_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  // message state: fill, bit count, chaining words
  always_ff @(posedge clk) begin
    if (!rst_n || reinit) begin
      fill_r     <= 6'd0;
      bit_cnt_r  <= 64'd0;
      chain_r[0] <= H0;
      chain_r[1] <= H1;
      chain_r[2] <= H2;
      chain_r[3] <= H3;
      chain_r[4] <= H4;
    end else begin
      if (absorb) begin
        fill_r <= fill_r + 6'd1;
      end
      if (in_fire && in_tuser) begin
        bit_cnt_r <= bit_cnt_r + 64'd8;
      end
      if (state_r == ST_ADD) begin
        chain_r[0] <= chain_r[0] + vars_r.a;
        chain_r[1] <= chain_r[1] + vars_r.b;
        chain_r[2] <= chain_r[2] + vars_r.c;
        chain_r[3] <= chain_r[3] + vars_r.d;
        chain_r[4] <= chain_r[4] + vars_r.e;
      end
    end
  end

  // byte packing and schedule shift line
  always_ff @(posedge clk) begin
    if (absorb) begin
      acc_r <= {acc_r[15:0], abs_byte};
    end
    if (absorb && (fill_r[1:0] == 2'b11)) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= {acc_r, abs_byte};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

  // working variables: load from chain at block start, then one round a cycle
  always_ff @(posedge clk) begin
    if (block_full) begin
      vars_r.a <= chain_r[0];
      vars_r.b <= chain_r[1];
      vars_r.c <= chain_r[2];
      vars_r.d <= chain_r[3];
      vars_r.e <= chain_r[4];
    end else if (state_r == ST_ROUND) begin
      vars_r <= vars_step;
    end
  end

  // digest word select
  always_comb begin
    case (out_idx_r)
      3'd0:    out_word = chain_r[0];
      3'd1:    out_word = chain_r[1];
      3'd2:    out_word = chain_r[2];
      3'd3:    out_word = chain_r[3];
      default: out_word = chain_r[4];
    endcase
  end

  assign out_tdata = {5'b00000, out_idx_r, out_word};
  assign out_tlast = (out_idx_r == LAST_IDX);

endmodule

`default_nettype wire

[sv/sha1_round.sv]
`timescale 1ns / 1ps
`default_nettype none

module sha1_round (
  input  logic [sha1_pkg::RND_W-1:0] rnd_i,
  input  sha1_pkg::sha1_vars_t       vars_i,
  input  logic [31:0]                w0_i,
  input  logic [31:0]                w2_i,
  input  logic [31:0]                w8_i,
  input  logic [31:0]                w13_i,
  output sha1_pkg::sha1_vars_t       vars_o,
  output logic [31:0]                w_new_o
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] x;

  // round function and constant by round group
  always_comb begin
    if (rnd_i inside {[7'd0:7'd19]}) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
      k = K0;
    end else if (rnd_i inside {[7'd20:7'd39]}) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K1;
    end else if (rnd_i inside {[7'd40:7'd59]}) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = K2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K3;
    end
  end

  // temp sum and variable rotation
  assign t = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + w0_i + k;

  always_comb begin
    vars_o.a = t;
    vars_o.b = vars_i.a;
    vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
    vars_o.d = vars_i.c;
    vars_o.e = vars_i.d;
  end

  // schedule expansion word, sixteen ahead of the current one
  assign x       = w13_i ^ w8_i ^ w2_i ^ w0_i;
  assign w_new_o = {x[30:0], x[31]};

endmodule

`default_nettype wire

[sv/sha1_hash_engine_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_engine_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire        out_tlast
);

  // no new byte is taken while a digest is being delivered
  a_no_input_during_output: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready
  ) else $error("input accepted while digest pending");

  // digest words count up by one
  a_index_steps: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tdata[34:32] == 3'($past(out_tdata[34:32]) + 3'd1)))
  ) else $error("digest word index did not advance");

  // exactly five words: the last one closes the digest
  a_done_after_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid
  ) else $error("digest word after last");

  // stalled word holds
  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata))
  ) else $error("stalled digest word changed");

endmodule

bind sha1_hash_engine sha1_hash_engine_chk u_sha1_chk (.*);

`default_nettype wire

[dv/tb_sha1_hash_engine.sv]
`timescale 1ns / 1ps

module tb_sha1_hash_engine;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS  = 210;
  localparam logic [159:0] EMPTY_DIGEST =
    160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;

  // one row of the directed table; digest is typed in only where known is set
  typedef struct packed {
    logic [7:0]   data;
    logic         has;
    logic         last;
    logic         known;
    logic [159:0] digest;
  } dir_row_t;

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned DIR_N = 19;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty message right after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    // idle words must leave the state alone
    '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
    // single byte on the last word, both extremes
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
    // "abc" with an idle word inside, last on the byte
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h3C, 1'b0, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b1, 1'b0, 160'h0},
    // "abc" again, ended by a bare last word
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hC3, 1'b0, 1'b1, 1'b0, 160'h0},
    // single-bit patterns and their complements
    '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
    '{8'hFE, 1'b1, 1'b1, 1'b0, 160'h0},
    // bare last with a junk byte is still the empty message
    '{8'h5A, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;  // data_byte[7:0]
  logic        in_tuser = 1'b0;   // has_byte
  logic        in_tlast = 1'b0;   // is_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // digest_word[31:0], word_index[34:32], zero[39:35]
  logic        out_tlast;         // last_word

  // hash state mirrored by the predictor
  logic [31:0] sha_chain [5];
  logic [31:0] sha_block [16];
  logic [63:0] sha_bits;
  logic [5:0]  sha_fill;

  digest_word_t digest_q [$];

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;

  sha1_hash_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // start a fresh message
  function automatic void sha_init();
    sha_chain[0] = sha1_pkg::H0;
    sha_chain[1] = sha1_pkg::H1;
    sha_chain[2] = sha1_pkg::H2;
    sha_chain[3] = sha1_pkg::H3;
    sha_chain[4] = sha1_pkg::H4;
    sha_bits = 64'd0;
    sha_fill = 6'd0;
  endfunction

  // 80 rounds over the current block, folded into the chaining words
  function automatic void sha_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = sha_block[i];
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
        w[r % 16] = {t[30:0], t[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + w[r % 16] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  // big-endian byte placement, compress on a full block
  function automatic void sha_absorb(input logic [7:0] b);
    logic [3:0] idx;
    int unsigned sh;
    idx = sha_fill[5:2];
    sh  = (3 - sha_fill[1:0]) * 8;
    if (sha_fill[1:0] == 2'd0) sha_block[idx] = {24'd0, b} << sh;
    else sha_block[idx] |= {24'd0, b} << sh;
    sha_fill = sha_fill + 6'd1;
    if (sha_fill == 6'd0) sha_compress();
  endfunction

  // one accepted input word; a last word pads and queues the digest
  function automatic void sha_predict(input logic [7:0] b, input logic has,
                                      input logic last);
    logic [63:0] len;
    digest_word_t dw;
    if (has) begin
      sha_absorb(b);
      sha_bits = sha_bits + 64'd8;  // wraps at 2^64 by width
    end
    if (last) begin
      len = sha_bits;
      sha_absorb(8'h80);
      while (sha_fill != 6'd56) sha_absorb(8'h00);
      sha_block[14] = len[63:32];
      sha_block[15] = len[31:0];
      sha_compress();
      for (int j = 0; j < 5; j++) begin
        dw.word  = sha_chain[j];
        dw.index = 3'(j);
        dw.last  = (j == 4);
        digest_q.insert(digest_q.size(), dw);
      end
      sha_init();
    end
  endfunction

  // drive one word, with a random lead-in gap, and wait for acceptance
  task automatic send_word(input logic [7:0] b, input logic has, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sha_predict(b, has, last);
    items_sent++;
  endtask

  // one well-formed message with random bytes and a few idle words mixed in
  task automatic send_message(input int unsigned len);
    logic last_on_byte;
    last_on_byte = (len > 0) && $urandom_range(1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
    end
    if (!last_on_byte) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // digest checker
  always @(posedge clk) begin
    digest_word_t dw;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", out_tdata);
        fail_count++;
      end else begin
        dw = digest_q.pop_front();
        if (out_tdata[31:0] !== dw.word) begin
          $error("digest_word: expected %h, got %h", dw.word, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[34:32] !== dw.index) begin
          $error("word_index: expected %0d, got %0d", dw.index, out_tdata[34:32]);
          fail_count++;
        end
        if (out_tlast !== dw.last) begin
          $error("last_word: expected %b, got %b", dw.last, out_tlast);
          fail_count++;
        end
        if (out_tdata[39:35] !== 5'd0) begin
          $error("zero: expected %h, got %h", 5'd0, out_tdata[39:35]);
          fail_count++;
        end
      end
    end
  end

  // count cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned base;
    sha_init();
    for (int i = 0; i < 16; i++) sha_block[i] = 32'd0;
    src_idle_pct = 22;
    dst_idle_pct = 73;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      send_word(DIR_ROWS[i].data, DIR_ROWS[i].has, DIR_ROWS[i].last);
      if (DIR_ROWS[i].known) begin
        base = digest_q.size() - 5;
        for (int j = 0; j < 5; j++)
          digest_q[base + j].word = DIR_ROWS[i].digest[159 - 32 * j -: 32];
      end
    end

    // random messages in three idling phases
    items_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 22; dst_idle_pct = 73; end
        1: begin src_idle_pct = 73; dst_idle_pct = 22; end
        default: begin src_idle_pct = 0; dst_idle_pct = 0; end
      endcase
      while (items_sent < RANDOM_ITEMS * (ph + 1) / 3) begin
        pick = $urandom_range(7);
        // lengths around the one- and two-block padding boundaries
        if (pick == 0) begin
          case ($urandom_range(4))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            default: len = 65;
          endcase
        end else begin
          len = $urandom_range(20);
        end
        send_message(len);
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
